FILE: hw/rtl/gas_sensor_frame_parser_assert.svh
// ----------------------------------------------------------------------------
// Gas sensor frame parser assertion macros
// Concurrent assertion wrappers used by the checker file gsfp_checker.sv.
// ----------------------------------------------------------------------------
`ifndef GAS_SENSOR_FRAME_PARSER_ASSERT_SVH
`define GAS_SENSOR_FRAME_PARSER_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define GSFP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define GSFP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/gsfp_pkg.sv
// ----------------------------------------------------------------------------
// Gas sensor frame parser package
// Frame constants and the result struct shared by the parser modules.
// ----------------------------------------------------------------------------
package gsfp_pkg;

  localparam logic [7:0] HdrFirst   = 8'h2C;
  localparam logic [7:0] HdrSecond  = 8'hE4;
  localparam int         FrameLen   = 9;
  localparam int         NumPayload = 6;
  localparam int         PosW       = 4;
  localparam int         IdxW       = $clog2(NumPayload);

  typedef logic [PosW-1:0] pos_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] tvoc;
    logic [15:0] ch2o;
    logic [15:0] eco2;
    logic        good;
  } frame_result_t;

endpackage

FILE: hw/rtl/gsfp_frame_tracker.sv
// ----------------------------------------------------------------------------
// Gas sensor frame tracker
// Tracks the byte position, running checksum and data bytes of a frame and
// flags a result on the checksum byte.
// ----------------------------------------------------------------------------
module gsfp_frame_tracker (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   byte_valid_i,
  input  logic [7:0]             byte_i,
  output gsfp_pkg::frame_result_t result_o
);
  import gsfp_pkg::*;

  localparam pos_t PosFirst  = pos_t'(0);
  localparam pos_t PosSecond = pos_t'(1);
  localparam pos_t PosCheck  = pos_t'(FrameLen - 1);

  pos_t            pos_q, pos_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      data_q [NumPayload];
  logic            data_we;
  logic [IdxW-1:0] data_idx;
  logic [PosW-1:0] idx_full;

  assign idx_full = pos_q - pos_t'(2);
  assign data_idx = idx_full[IdxW-1:0];

  always_comb begin
    pos_d    = pos_q;
    sum_d    = sum_q;
    data_we  = 1'b0;
    result_o = '0;
    result_o.tvoc = {data_q[0], data_q[1]};
    result_o.ch2o = {data_q[2], data_q[3]};
    result_o.eco2 = {data_q[4], data_q[5]};
    result_o.good = (sum_q == byte_i);
    if (byte_valid_i) begin
      priority if (pos_q == PosFirst) begin
        if (byte_i == HdrFirst) begin
          sum_d = byte_i;
          pos_d = PosSecond;
        end else begin
          pos_d = PosFirst;
        end
      end else if (pos_q == PosSecond) begin
        if (byte_i == HdrSecond) begin
          sum_d = sum_q + byte_i;
          pos_d = pos_t'(2);
        end else begin
          pos_d = PosFirst;
        end
      end else if (pos_q < PosCheck) begin
        data_we = 1'b1;
        sum_d   = sum_q + byte_i;
        pos_d   = pos_q + pos_t'(1);
      end else if (pos_q == PosCheck) begin
        result_o.valid = 1'b1;
        sum_d          = '0;
        pos_d          = PosFirst;
      end else begin
        // unreachable position: drop back to header hunt
        pos_d = PosFirst;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= PosFirst;
      sum_q <= '0;
    end else begin
      pos_q <= pos_d;
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (data_we) begin
      data_q[data_idx] <= byte_i;
    end
  end

endmodule

FILE: hw/rtl/gas_sensor_frame_parser.sv
// ----------------------------------------------------------------------------
// Gas sensor frame parser
// Hunts a serial byte stream for nine-byte sensor frames and reports the
// three readings with a checksum flag.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle while in_ready_o is high. A frame is 0x2C 0xE4, TVOC, CH2O and
// eCO2 as big-endian 16-bit words, then a byte that must equal the modulo-256
// sum of the first eight. The checksum byte produces one result on the next
// cycle from the output register, good or not; every other byte produces
// none. A wrong header byte restarts the hunt and is not retried as a header
// start. in_ready_o stays high except while a result waits in the output
// register with out_ready_i low, so the sustained rate is one byte per cycle.
// ----------------------------------------------------------------------------
module gas_sensor_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] tvoc_value_o,
  output logic [15:0] formaldehyde_value_o,
  output logic [15:0] co2_equivalent_value_o,
  output logic        frame_good_o
);
  import gsfp_pkg::*;

  logic          in_accept;
  frame_result_t result;
  logic          out_valid_q, out_valid_d;
  logic [15:0]   tvoc_q, ch2o_q, eco2_q;
  logic          good_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  gsfp_frame_tracker u_tracker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (in_accept),
    .byte_i       (rx_byte_i),
    .result_o     (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (result.valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // load the result register only when a frame completes
  always_ff @(posedge clk_i) begin
    if (result.valid) begin
      tvoc_q <= result.tvoc;
      ch2o_q <= result.ch2o;
      eco2_q <= result.eco2;
      good_q <= result.good;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign tvoc_value_o          = tvoc_q;
  assign formaldehyde_value_o  = ch2o_q;
  assign co2_equivalent_value_o = eco2_q;
  assign frame_good_o          = good_q;

endmodule

FILE: hw/rtl/gsfp_checker.sv
// ----------------------------------------------------------------------------
// Gas sensor frame parser checker
// Port-level assertions on the parser, attached by bind.
// ----------------------------------------------------------------------------
`include "gas_sensor_frame_parser_assert.svh"

module gsfp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  rx_byte_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] tvoc_value_o,
  input logic [15:0] formaldehyde_value_o,
  input logic [15:0] co2_equivalent_value_o,
  input logic        frame_good_o
);

  logic        in_wait;
  logic        out_stall;
  logic [48:0] reading;

  assign in_wait   = in_valid_i && !in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;
  assign reading   = {tvoc_value_o, formaldehyde_value_o, co2_equivalent_value_o,
                      frame_good_o};

  // a pending result holds until taken
  `GSFP_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> out_valid_o && $stable(reading), "result dropped or changed while stalled")

  // a waiting request holds its byte until taken
  `GSFP_ASSERT(a_in_hold, clk_i, rst_ni, in_wait |=> in_valid_i && $stable(rx_byte_i), "request dropped or changed while stalled")

  // an empty output register never blocks a request
  `GSFP_ASSERT(a_ready_when_empty, clk_i, rst_ni, !out_valid_o |-> in_ready_o, "input stalled with output register empty")

  // a new result only follows an accepted request
  `GSFP_ASSERT(a_result_cause, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o), "result without an accepted byte")

  `GSFP_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !out_valid_o, "result valid during reset")

endmodule

bind gas_sensor_frame_parser gsfp_checker u_gsfp_checker (.*);
